FILE: hdl/sll_pkg.sv
// Shared constants and types for the sequential list engine.
`default_nettype none
package sll_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = ((CNT_W > 8) ? CNT_W : 8) + 1;

  typedef enum logic [2:0] {
    REQ_CLEAR  = 3'd0,
    REQ_GET    = 3'd1,
    REQ_FIND   = 3'd2,
    REQ_INSERT = 3'd3,
    REQ_DELETE = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_LEFT  = 2'd2,
    CELL_RIGHT = 2'd3
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      active;
  } cell_ctl_t;

endpackage
`default_nettype wire

FILE: hdl/sequential_list_engine.sv
// Top level of the sequential list engine: request decode, cell row and result register.
//
// Usage: requests arrive on the in_ channel (in_req_type, in_position, in_value)
// and each transfer produces exactly one result on the out_ channel (out_status,
// out_elem_out, out_found_pos, out_count, out_is_empty). A transfer happens on a
// rising edge with valid high and stall low.
// The output register loads on the edge of the request's transfer and the
// result can transfer on the next edge. Throughput is one request per cycle
// while the receiver does not stall; the row of cells shifts or compares every
// slot in the same cycle, so insert, delete and find all complete in a single step regardless of position.
// When the receiver stalls, the result register holds and in_stall rises, so
// no further request is taken until the pending result is transferred.
// Reset (rst_n low, synchronous) empties the list and drops any pending result;
// element contents are not cleared and are never read before being written.
// Positions are 1-based; out-of-range, full, empty and unmatched requests
// return status 1 and leave the list unchanged.
`default_nettype none
module sequential_list_engine (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [2:0]        in_req_type,
  input  wire logic [7:0]        in_position,
  input  wire logic signed [31:0] in_value,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_status,
  output logic signed [31:0]     out_elem_out,
  output logic [4:0]             out_found_pos,
  output logic [4:0]             out_count,
  output logic                   out_is_empty
);

  localparam int CAP   = sll_pkg::CAPACITY;
  localparam int CNT_W = sll_pkg::CNT_W;
  localparam int CMP_W = sll_pkg::CMP_W;
  localparam int IDX_W = sll_pkg::IDX_W;

  logic [CNT_W-1:0]   fill_r;
  logic [CNT_W-1:0]   fill_nxt;
  logic               out_valid_r;
  logic               out_status_r;
  logic signed [31:0] out_elem_r;
  logic [4:0]         out_found_r;

  logic               accept;
  logic [CMP_W-1:0]   pos_w;
  logic [CMP_W-1:0]   fill_w;
  logic [CMP_W-1:0]   pos_m1;
  logic               pos_nz;
  logic               rd_ok;
  logic               ins_ok;
  logic               do_ins;
  logic               do_del;
  logic               status_nxt;
  logic signed [31:0] elem_nxt;
  logic [CNT_W-1:0]   found_idx;
  logic               any_hit;

  sll_pkg::cell_ctl_t cell_ctl  [CAP];
  logic signed [31:0] cell_data [CAP];
  logic               cell_first[CAP];
  logic               hit       [CAP+1];

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign pos_w  = CMP_W'(in_position);
  assign fill_w = CMP_W'(fill_r);
  assign pos_m1 = pos_w - CMP_W'(1);
  assign pos_nz = (in_position != 8'd0);
  assign rd_ok  = pos_nz && (pos_w <= fill_w);
  assign ins_ok = (fill_w < CMP_W'(CAP)) && pos_nz && (pos_w <= fill_w + CMP_W'(1));
  assign do_ins = accept && (in_req_type == sll_pkg::REQ_INSERT) && ins_ok;
  assign do_del = accept && (in_req_type == sll_pkg::REQ_DELETE) && rd_ok;

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    localparam logic [CMP_W-1:0] IDX = CMP_W'(i);

    always_comb begin
      cell_ctl[i].active = (IDX < fill_w);
      priority if (do_ins && IDX == pos_m1) begin
        cell_ctl[i].cmd = sll_pkg::CELL_LOAD;
      end else if (do_ins && IDX > pos_m1 && IDX <= fill_w) begin
        cell_ctl[i].cmd = sll_pkg::CELL_LEFT;
      end else if (do_del && IDX >= pos_m1 && IDX + CMP_W'(1) < fill_w) begin
        cell_ctl[i].cmd = sll_pkg::CELL_RIGHT;
      end else begin
        cell_ctl[i].cmd = sll_pkg::CELL_HOLD;
      end
    end

    sll_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[i]),
      .load_data  (in_value),
      .left_data  (cell_data[(i == 0) ? 0 : i - 1]),
      .right_data (cell_data[(i == CAP - 1) ? i : i + 1]),
      .key        (in_value),
      .hit_in     (hit[i]),
      .data       (cell_data[i]),
      .hit_out    (hit[i+1]),
      .first      (cell_first[i])
    );
  end

  always_comb begin
    found_idx = '0;
    for (int i = 0; i < CAP; i++) begin
      if (cell_first[i]) begin
        found_idx = found_idx | CNT_W'(i + 1);
      end
    end
  end

  assign any_hit = hit[CAP];

  always_comb begin
    status_nxt = 1'b1;
    elem_nxt   = '0;
    fill_nxt   = fill_r;
    unique case (in_req_type)
      sll_pkg::REQ_CLEAR: begin
        status_nxt = 1'b0;
        fill_nxt   = '0;
      end
      sll_pkg::REQ_GET: begin
        if (rd_ok) begin
          status_nxt = 1'b0;
          elem_nxt   = cell_data[pos_m1[IDX_W-1:0]];
        end
      end
      sll_pkg::REQ_FIND: begin
        status_nxt = !any_hit;
      end
      sll_pkg::REQ_INSERT: begin
        if (ins_ok) begin
          status_nxt = 1'b0;
          fill_nxt   = fill_r + CNT_W'(1);
        end
      end
      sll_pkg::REQ_DELETE: begin
        if (rd_ok) begin
          status_nxt = 1'b0;
          elem_nxt   = cell_data[pos_m1[IDX_W-1:0]];
          fill_nxt   = fill_r - CNT_W'(1);
        end
      end
      default: begin
        status_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        fill_r      <= fill_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= status_nxt;
      out_elem_r   <= elem_nxt;
      out_found_r  <= (in_req_type == sll_pkg::REQ_FIND) ? 5'(found_idx) : 5'd0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_elem_out  = out_elem_r;
  assign out_found_pos = out_found_r;
  assign out_count     = 5'(fill_r);
  assign out_is_empty  = (fill_r == '0);

endmodule
`default_nettype wire

FILE: hdl/sll_cell.sv
// One list slot: holds an element, shifts with its neighbors, compares against the key.
`default_nettype none
module sll_cell (
  input  wire logic              clk,
  input  wire sll_pkg::cell_ctl_t ctl,
  input  wire logic signed [31:0] load_data,
  input  wire logic signed [31:0] left_data,
  input  wire logic signed [31:0] right_data,
  input  wire logic signed [31:0] key,
  input  wire logic              hit_in,
  output logic signed [31:0]     data,
  output logic                   hit_out,
  output logic                   first
);

  logic signed [31:0] data_r;
  logic signed [31:0] data_nxt;
  logic               match;

  always_comb begin
    unique case (ctl.cmd)
      sll_pkg::CELL_HOLD:  data_nxt = data_r;
      sll_pkg::CELL_LOAD:  data_nxt = load_data;
      sll_pkg::CELL_LEFT:  data_nxt = left_data;
      sll_pkg::CELL_RIGHT: data_nxt = right_data;
      default:             data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign match   = ctl.active && (data_r == key);
  assign first   = match && !hit_in;
  assign hit_out = hit_in || match;
  assign data    = data_r;

endmodule
`default_nettype wire

FILE: hdl/sll_checker.sv
// Port-level assertions for the sequential list engine and their bind.
`default_nettype none
module sll_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic              out_status,
  input wire logic signed [31:0] out_elem_out,
  input wire logic [4:0]        out_found_pos,
  input wire logic [4:0]        out_count,
  input wire logic              out_is_empty
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_accept_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("transfer produced no result");

  a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_elem_out == 32'sd0 && out_found_pos == 5'd0)
    else $error("error result carries data");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_count == 5'd0)) &&
                  (32'(out_count) <= sll_pkg::CAPACITY || sll_pkg::CAPACITY > 31))
    else $error("empty flag or count inconsistent");

endmodule

bind sequential_list_engine sll_checker u_sll_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_status    (out_status),
  .out_elem_out  (out_elem_out),
  .out_found_pos (out_found_pos),
  .out_count     (out_count),
  .out_is_empty  (out_is_empty)
);
`default_nettype wire
